// ----- rtl/diff_drive_wheel_command_slew_assert.svh -----
// ============================================================================
// diff_drive_wheel_command_slew assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ============================================================================
`ifndef DIFF_DRIVE_WHEEL_COMMAND_SLEW_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_COMMAND_SLEW_ASSERT_SVH
`ifndef SYNTHESIS
`define DDWCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ddwcs: assertion failed");
`define DDWCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ddwcs: assertion failed");
`else
`define DDWCS_ASSERT(label, clk, rst_n, prop)
`define DDWCS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/ddwcs_pkg.sv -----
// ============================================================================
// ddwcs_pkg
// Widths, constants, codes and types of the wheel command slew block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ddwcs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int HT_W  = 10;
    localparam int LIM_W = 21;
    localparam int ACC_W = 24;
    localparam int SB_W  = 17;

    localparam int IN_W  = 16;
    localparam int EL_W  = 20;
    localparam int CMD_W = 22;

    localparam int DZ_W   = HT_W + IN_W;
    localparam int TGT_W  = 28;
    localparam int MAG_W  = 27;
    localparam int GAP_W  = 24;
    localparam int GAPM_W = 23;

    localparam int MA_W   = 27;
    localparam int MB_W   = 25;
    localparam int PROD_W = MA_W + MB_W;
    localparam int QUO_W  = 25;
    localparam int DIV_W  = PROD_W - QUO_W;

    localparam int UM_PER_MM = 1000;
    localparam logic [DIV_W-1:0] US_PER_S = DIV_W'(1000000);

    localparam logic [HT_W-1:0]  HT_RST  = HT_W'(40);
    localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(100000);
    localparam logic [ACC_W-1:0] ACC_RST = ACC_W'(1500000);
    localparam logic [SB_W-1:0]  SB_RST  = SB_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_TRACK,
        CFG_MAX_SPEED,
        CFG_MAX_ACCEL,
        CFG_STOP_BAND
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DZ,
        S_TGT,
        S_CHK,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_GAP,
        S_SNAP,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_SL,
        OP_SR,
        OP_FULL,
        OP_GL,
        OP_GR
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- rtl/ddwcs_in_if.sv -----
// ============================================================================
// ddwcs_in_if
// Body command channel: valid/ready with speed, turn rate and elapsed time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ddwcs_in_if;
    import ddwcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] forward_speed;
    logic signed [IN_W-1:0] turn_rate;
    logic [EL_W-1:0]        elapsed_us;

    modport source (output valid, forward_speed, turn_rate, elapsed_us, input ready);
    modport sink   (input valid, forward_speed, turn_rate, elapsed_us, output ready);
endinterface

`default_nettype wire

// ----- rtl/ddwcs_out_if.sv -----
// ============================================================================
// ddwcs_out_if
// Wheel command channel: valid/ready with left and right commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ddwcs_out_if;
    import ddwcs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] left_command;
    logic signed [CMD_W-1:0] right_command;

    modport source (output valid, left_command, right_command, input ready);
    modport sink   (input valid, left_command, right_command, output ready);
endinterface

`default_nettype wire

// ----- rtl/diff_drive_wheel_command_slew.sv -----
// ============================================================================
// diff_drive_wheel_command_slew
// Turns a body command (forward speed, turn rate, elapsed time) into slew
// limited left and right wheel speed commands in um/s.
// i_in carries one command item; o_out returns one wheel command item for it.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user
// must make them only while no item is in flight, the block does not enforce it.
// One shared multiplier and one divider do the multiplies and divides under a
// sequencer; each pass runs through the S_MUL, S_DIVS and S_DIVW states.
// When both wheels sit on target the slew passes are skipped; targets over
// the speed limit add two scaling passes first.
// One item in flight: i_in.ready is high only when idle, so a new item is
// taken only after the sequencer has finished the last one.
// The finished result sits in an output register; a stalled receiver holds
// it there while the next item is processed, and the sequencer waits at the
// end only if the output register is still full.
// Reset clears both wheel commands to zero, restores register defaults
// and drops o_out.valid.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "diff_drive_wheel_command_slew_assert.svh"

module diff_drive_wheel_command_slew (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ddwcs_in_if.sink                              i_in,
    ddwcs_out_if.source                           o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [ddwcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ddwcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddwcs_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [HT_W-1:0]  r_half_track;
    logic [LIM_W-1:0] r_max_speed;
    logic [ACC_W-1:0] r_max_accel;
    logic [SB_W-1:0]  r_stop_band;

    logic signed [IN_W-1:0]  r_x, r_z;
    logic [EL_W-1:0]         r_el;
    logic signed [TGT_W-1:0] r_tl, r_tr;
    logic [MAG_W-1:0]        r_m;
    logic signed [GAP_W-1:0] r_gl, r_gr;
    logic [GAPM_W-1:0]       r_maxgap;
    logic [QUO_W-1:0]        r_full;
    logic signed [CMD_W-1:0] r_lcmd, r_rcmd;
    logic signed [CMD_W-1:0] r_out_l, r_out_r;
    logic                    r_out_valid;

    logic                    w_out_load;
    logic [IN_W-1:0]         w_z_mag;
    logic signed [TGT_W-1:0] w_x_um, w_dz, w_tl, w_tr;
    logic signed [TGT_W-1:0] w_new_gl, w_new_gr, w_quo_s;
    logic [MAG_W-1:0]        w_ml, w_mr, w_lmag, w_rmag;
    logic [GAPM_W-1:0]       w_new_glm, w_new_grm, w_maxgap, w_glm, w_grm;
    logic                    w_scale;

    logic              w_mul_en;
    logic [MA_W-1:0]   w_mul_a;
    logic [MB_W-1:0]   w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_divisor;
    logic [QUO_W-1:0]  w_quo;
    t_div_stat         w_div_stat;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [TGT_W-1:0] v);
        logic signed [TGT_W-1:0] a;
        a = v[TGT_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic signed [CMD_W-1:0] f_slew(
        input logic signed [CMD_W-1:0] cmd,
        input logic signed [TGT_W-1:0] tgt,
        input logic signed [GAP_W-1:0] gap,
        input logic [QUO_W-1:0]        q
    );
        logic [MAG_W-1:0]        gm;
        logic signed [TGT_W-1:0] stp;
        logic signed [TGT_W-1:0] nxt;
        gm  = f_mag(TGT_W'(gap));
        stp = gap[GAP_W-1] ? -$signed(TGT_W'(q)) : $signed(TGT_W'(q));
        if (TGT_W'(gm) >= TGT_W'(q)) begin
            nxt = TGT_W'(cmd) + stp;
        end else begin
            nxt = tgt;
        end
        return nxt[CMD_W-1:0];
    endfunction

    ddwcs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ddwcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    // target forming and gap datapath
    always_comb begin
        w_z_mag   = r_z[IN_W-1] ? (~$unsigned(r_z) + 1'b1) : $unsigned(r_z);
        w_x_um    = TGT_W'(r_x) * $signed(TGT_W'(UM_PER_MM));
        w_dz      = r_z[IN_W-1] ? -$signed(TGT_W'(w_prod[DZ_W-1:0]))
                                :  $signed(TGT_W'(w_prod[DZ_W-1:0]));
        w_tl      = w_x_um - w_dz;
        w_tr      = -(w_x_um + w_dz);
        w_ml      = f_mag(r_tl);
        w_mr      = f_mag(r_tr);
        w_scale   = (w_ml > MAG_W'(r_max_speed)) || (w_mr > MAG_W'(r_max_speed));
        w_new_gl  = r_tl - TGT_W'(r_lcmd);
        w_new_gr  = r_tr - TGT_W'(r_rcmd);
        w_new_glm = GAPM_W'(f_mag(w_new_gl));
        w_new_grm = GAPM_W'(f_mag(w_new_gr));
        w_maxgap  = (w_new_glm > w_new_grm) ? w_new_glm : w_new_grm;
        w_glm     = GAPM_W'(f_mag(TGT_W'(r_gl)));
        w_grm     = GAPM_W'(f_mag(TGT_W'(r_gr)));
        w_quo_s   = $signed(TGT_W'(w_quo));
        w_lmag    = f_mag(TGT_W'(r_lcmd));
        w_rmag    = f_mag(TGT_W'(r_rcmd));
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        w_mul_en    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_op)
            OP_SL: begin
                w_mul_a   = w_ml;
                w_mul_b   = MB_W'(r_max_speed);
                w_divisor = r_m;
            end
            OP_SR: begin
                w_mul_a   = w_mr;
                w_mul_b   = MB_W'(r_max_speed);
                w_divisor = r_m;
            end
            OP_FULL: begin
                w_mul_a   = MA_W'(r_max_accel);
                w_mul_b   = MB_W'(r_el);
                w_divisor = US_PER_S;
            end
            OP_GL: begin
                w_mul_a   = MA_W'(w_glm);
                w_mul_b   = r_full;
                w_divisor = DIV_W'(r_maxgap);
            end
            OP_GR: begin
                w_mul_a   = MA_W'(w_grm);
                w_mul_b   = r_full;
                w_divisor = DIV_W'(r_maxgap);
            end
            default: begin
                w_mul_a   = '0;
                w_mul_b   = '0;
                w_divisor = US_PER_S;
            end
        endcase
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DZ;
                end
            end
            S_DZ: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA_W'(r_half_track);
                w_mul_b  = MB_W'(w_z_mag);
                n_state  = S_TGT;
            end
            S_TGT: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (w_scale) begin
                    n_op    = OP_SL;
                    n_state = S_MUL;
                end else begin
                    n_state = S_GAP;
                end
            end
            S_MUL: begin
                w_mul_en = 1'b1;
                n_state  = S_DIVS;
            end
            S_DIVS: begin
                w_div_start = 1'b1;
                n_state     = S_DIVW;
            end
            S_DIVW: begin
                if (w_div_stat.done) begin
                    case (r_op)
                        OP_SL: begin
                            n_op    = OP_SR;
                            n_state = S_MUL;
                        end
                        OP_SR: begin
                            n_state = S_GAP;
                        end
                        OP_FULL: begin
                            n_op    = OP_GL;
                            n_state = S_MUL;
                        end
                        OP_GL: begin
                            n_op    = OP_GR;
                            n_state = S_MUL;
                        end
                        OP_GR: begin
                            n_state = S_SNAP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_GAP: begin
                if (w_maxgap == '0) begin
                    n_state = S_SNAP;
                end else begin
                    n_op    = OP_FULL;
                    n_state = S_MUL;
                end
            end
            S_SNAP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_SL;
            r_half_track <= HT_RST;
            r_max_speed  <= LIM_RST;
            r_max_accel  <= ACC_RST;
            r_stop_band  <= SB_RST;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HALF_TRACK: r_half_track <= i_cfg_data[HT_W-1:0];
                    CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data[LIM_W-1:0];
                    CFG_MAX_ACCEL:  r_max_accel  <= i_cfg_data[ACC_W-1:0];
                    CFG_STOP_BAND:  r_stop_band  <= i_cfg_data[SB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // wheel commands and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcmd      <= '0;
            r_rcmd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DIVW && w_div_stat.done && r_op == OP_GL) begin
                r_lcmd <= f_slew(r_lcmd, r_tl, r_gl, w_quo);
            end
            if (r_state == S_DIVW && w_div_stat.done && r_op == OP_GR) begin
                r_rcmd <= f_slew(r_rcmd, r_tr, r_gr, w_quo);
            end
            if (r_state == S_SNAP) begin
                if (r_tl == '0 && w_lmag <= MAG_W'(r_stop_band)) begin
                    r_lcmd <= '0;
                end
                if (r_tr == '0 && w_rmag <= MAG_W'(r_stop_band)) begin
                    r_rcmd <= '0;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_x  <= i_in.forward_speed;
                    r_z  <= i_in.turn_rate;
                    r_el <= i_in.elapsed_us;
                end
            end
            S_TGT: begin
                r_tl <= w_tl;
                r_tr <= w_tr;
            end
            S_CHK: begin
                r_m <= (w_ml > w_mr) ? w_ml : w_mr;
            end
            S_DIVW: begin
                if (w_div_stat.done) begin
                    case (r_op)
                        OP_SL:   r_tl   <= r_tl[TGT_W-1] ? -w_quo_s : w_quo_s;
                        OP_SR:   r_tr   <= r_tr[TGT_W-1] ? -w_quo_s : w_quo_s;
                        OP_FULL: r_full <= w_quo;
                        default: ;
                    endcase
                end
            end
            S_GAP: begin
                r_gl     <= w_new_gl[GAP_W-1:0];
                r_gr     <= w_new_gr[GAP_W-1:0];
                r_maxgap <= w_maxgap;
            end
            S_FIN: begin
                if (w_out_load) begin
                    r_out_l <= r_lcmd;
                    r_out_r <= r_rcmd;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.left_command  = r_out_l;
    assign o_out.right_command = r_out_r;

    `DDWCS_ASSERT(a_div_start_idle, i_clk, i_rst_n, w_div_start |-> !w_div_stat.busy)
    `DDWCS_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready)
    `DDWCS_ASSERT(a_snap_left, i_clk, i_rst_n, (r_state == S_FIN && r_tl == '0) |->
        (r_lcmd == '0 || w_lmag > MAG_W'(r_stop_band)))
    `DDWCS_ASSERT(a_load_valid, i_clk, i_rst_n, w_out_load |=> o_out.valid)
    `DDWCS_ASSERT_ALWAYS(a_reset_clears, i_clk, (!i_rst_n) |=> !o_out.valid)

endmodule

`default_nettype wire

// ----- rtl/ddwcs_mul.sv -----
// ============================================================================
// ddwcs_mul
// Shared unsigned multiplier with registered product.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ddwcs_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ddwcs_pkg::MA_W-1:0]    i_a,
    input  wire logic [ddwcs_pkg::MB_W-1:0]    i_b,
    output logic      [ddwcs_pkg::PROD_W-1:0]  o_prod
);
    import ddwcs_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/ddwcs_div.sv -----
// ============================================================================
// ddwcs_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "diff_drive_wheel_command_slew_assert.svh"

module ddwcs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ddwcs_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [ddwcs_pkg::DIV_W-1:0]   i_divisor,
    output logic      [ddwcs_pkg::QUO_W-1:0]   o_quotient,
    output ddwcs_pkg::t_div_stat               o_stat
);
    import ddwcs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dsr;
    logic [QUO_W-1:0] r_q, n_q;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_q[QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_q     = r_q;
        if (i_start) begin
            n_cnt = CNT_W'(QUO_W);
            n_rem = i_dividend[PROD_W-1:QUO_W];
            n_q   = i_dividend[QUO_W-1:0];
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = w_diff[DIV_W-1:0];
                n_q   = {r_q[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_W-1:0];
                n_q   = {r_q[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_quotient  = r_q;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

    `DDWCS_ASSERT(a_done_not_busy, i_clk, i_rst_n, r_done |-> r_cnt == '0)
    `DDWCS_ASSERT(a_start_busy, i_clk, i_rst_n, i_start |=> o_stat.busy)
    `DDWCS_ASSERT(a_done_single, i_clk, i_rst_n, r_done |=> !r_done)

endmodule

`default_nettype wire

// ----- dv/wheel_command_checker.sv -----
// ============================================================================
// wheel_command_checker
// Watches the body command and wheel command channels and the register
// write port, predicts the slew limited wheel commands for every accepted
// item and compares them field by field with the items the block returns.
// ============================================================================
`timescale 1ns / 1ps

module wheel_command_checker
    import ddwcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ddwcs_in_if                   i_body,
    ddwcs_out_if                  i_wheel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    localparam longint UM_IN_MM   = 1000;
    localparam longint US_PER_SEC = 1000000;

    localparam logic [HT_W-1:0]  HALF_TRACK_DEFAULT = HT_W'(40);
    localparam logic [LIM_W-1:0] SPEED_DEFAULT      = LIM_W'(100000);
    localparam logic [ACC_W-1:0] ACCEL_DEFAULT      = ACC_W'(1500000);
    localparam logic [SB_W-1:0]  BAND_DEFAULT       = SB_W'(1000);

    typedef struct packed {
        logic signed [CMD_W-1:0] left;
        logic signed [CMD_W-1:0] right;
    } wheel_pair_t;

    logic [HT_W-1:0]         half_track;
    logic [LIM_W-1:0]        speed_limit;
    logic [ACC_W-1:0]        accel_limit;
    logic [SB_W-1:0]         stop_band;
    logic signed [CMD_W-1:0] left_cmd;
    logic signed [CMD_W-1:0] right_cmd;

    wheel_pair_t expected_commands[$];
    wheel_pair_t got;
    wheel_pair_t want;
    int          fail_count = 0;

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // trunc(v * num / den) toward zero
    function automatic longint scale_trunc(input longint v, input longint num,
                                           input longint den);
        longint q;
        q = (abs64(v) * num) / den;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint slew_toward(input longint cmd, input longint tgt,
                                           input longint full, input longint max_gap);
        longint gap;
        longint step;
        gap  = tgt - cmd;
        step = scale_trunc(gap, full, max_gap);
        return (abs64(gap) >= abs64(step)) ? cmd + step : tgt;
    endfunction

    function automatic wheel_pair_t advance_wheels(input logic signed [IN_W-1:0] fwd,
                                                   input logic signed [IN_W-1:0] turn,
                                                   input logic [EL_W-1:0] el);
        longint lim;
        longint ht;
        longint tgt_l;
        longint tgt_r;
        longint peak;
        longint next_l;
        longint next_r;
        longint max_gap;
        longint full;
        wheel_pair_t res;
        lim   = longint'(speed_limit);
        ht    = longint'(half_track);
        tgt_l = longint'(fwd) * UM_IN_MM - ht * longint'(turn);
        tgt_r = -(longint'(fwd) * UM_IN_MM + ht * longint'(turn));
        if (abs64(tgt_l) > lim || abs64(tgt_r) > lim) begin
            peak  = (abs64(tgt_l) > abs64(tgt_r)) ? abs64(tgt_l) : abs64(tgt_r);
            tgt_l = scale_trunc(tgt_l, lim, peak);
            tgt_r = scale_trunc(tgt_r, lim, peak);
        end
        next_l  = longint'(left_cmd);
        next_r  = longint'(right_cmd);
        max_gap = (abs64(tgt_l - next_l) > abs64(tgt_r - next_r)) ?
                  abs64(tgt_l - next_l) : abs64(tgt_r - next_r);
        if (max_gap != 0) begin
            full   = longint'(accel_limit) * longint'(el) / US_PER_SEC;
            next_l = slew_toward(next_l, tgt_l, full, max_gap);
            next_r = slew_toward(next_r, tgt_r, full, max_gap);
        end
        if (tgt_l == 0 && abs64(next_l) <= longint'(stop_band)) next_l = 0;
        if (tgt_r == 0 && abs64(next_r) <= longint'(stop_band)) next_r = 0;
        left_cmd  = CMD_W'(next_l);
        right_cmd = CMD_W'(next_r);
        res.left  = left_cmd;
        res.right = right_cmd;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_track  = HALF_TRACK_DEFAULT;
            speed_limit = SPEED_DEFAULT;
            accel_limit = ACCEL_DEFAULT;
            stop_band   = BAND_DEFAULT;
            left_cmd    = '0;
            right_cmd   = '0;
            expected_commands.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HALF_TRACK: half_track  = i_cfg_data[HT_W-1:0];
                    CFG_MAX_SPEED:  speed_limit = i_cfg_data[LIM_W-1:0];
                    CFG_MAX_ACCEL:  accel_limit = i_cfg_data[ACC_W-1:0];
                    CFG_STOP_BAND:  stop_band   = i_cfg_data[SB_W-1:0];
                    default: ;
                endcase
            end
            if (i_wheel.valid && i_wheel.ready) begin
                got.left  = i_wheel.left_command;
                got.right = i_wheel.right_command;
                if (expected_commands.size() == 0) begin
                    $error("wheel command item with none expected: left %0d right %0d",
                           got.left, got.right);
                    fail_count++;
                end else begin
                    want = expected_commands.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_command: expected %0d, got %0d", want.left, got.left);
                        fail_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_command: expected %0d, got %0d", want.right,
                               got.right);
                        fail_count++;
                    end
                end
            end
            if (i_body.valid && i_body.ready) begin
                expected_commands.push_back(advance_wheels(i_body.forward_speed,
                                                           i_body.turn_rate,
                                                           i_body.elapsed_us));
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_commands.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// ============================================================================
// tb_top
// Drives body command items into the wheel command slew block under several
// register settings, directed corner items first and then held commands with
// random elapsed times, with random stalls on both channels. A checker beside
// the block predicts and compares every returned item.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import ddwcs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 160;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycles = 0;
    bit                    idle_on = 1'b1;
    int                    cur_half_track = 40;

    ddwcs_in_if  body_ch ();
    ddwcs_out_if wheel_ch ();

    always #5 clk = ~clk;

    diff_drive_wheel_command_slew u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (body_ch),
        .o_out      (wheel_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    wheel_command_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_body        (body_ch),
        .i_wheel       (wheel_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        wheel_ch.ready = 1'b0;
        @(posedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                wheel_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            wheel_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_body(input int fwd, input int turn, input int el);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            body_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        body_ch.valid         <= 1'b1;
        body_ch.forward_speed <= IN_W'(fwd);
        body_ch.turn_rate     <= IN_W'(turn);
        body_ch.elapsed_us    <= EL_W'(el);
        @(posedge clk);
        while (!body_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        body_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_registers(input int ht, input int lim, input int acc, input int sb);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HALF_TRACK;
        cfg_data <= CFG_DATA_W'(ht);
        @(posedge clk);
        cfg_idx  <= CFG_MAX_SPEED;
        cfg_data <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_idx  <= CFG_MAX_ACCEL;
        cfg_data <= CFG_DATA_W'(acc);
        @(posedge clk);
        cfg_idx  <= CFG_STOP_BAND;
        cfg_data <= CFG_DATA_W'(sb);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_half_track = ht & ((1 << HT_W) - 1);
    endtask

    // commands are held for a few items so the wheels ramp toward them
    task automatic run_random(input int count);
        int fwd;
        int turn;
        int el;
        int hold;
        int k;
        fwd  = 0;
        turn = 0;
        hold = 0;
        for (int n = 0; n < count; n++) begin
            if (hold == 0) begin
                hold = $urandom_range(1, 8);
                case ($urandom_range(0, 6))
                    0: begin
                        fwd  = 0;
                        turn = 0;
                    end
                    1: begin
                        fwd  = int'($urandom_range(0, 65535)) - 32768;
                        turn = int'($urandom_range(0, 65535)) - 32768;
                    end
                    2: begin
                        // near the stop band
                        fwd  = int'($urandom_range(0, 4)) - 2;
                        turn = int'($urandom_range(0, 40)) - 20;
                    end
                    3: begin
                        // pivot about one wheel, its target is zero
                        k    = int'($urandom_range(0, 64)) - 32;
                        fwd  = cur_half_track * k;
                        turn = ($urandom_range(0, 1) == 0) ? k * 1000 : -k * 1000;
                    end
                    default: begin
                        fwd  = int'($urandom_range(0, 4000)) - 2000;
                        turn = int'($urandom_range(0, 8000)) - 4000;
                    end
                endcase
            end
            hold--;
            case ($urandom_range(0, 9))
                0:       el = 0;
                1:       el = $urandom_range(0, 1048575);
                2:       el = $urandom_range(1, 999);
                default: el = $urandom_range(1000, 50000);
            endcase
            send_body(fwd, turn, el);
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_HALF_TRACK;
        cfg_data              = '0;
        body_ch.valid         = 1'b0;
        body_ch.forward_speed = '0;
        body_ch.turn_rate     = '0;
        body_ch.elapsed_us    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        send_body(0, 0, 0);
        send_body(100, 0, 1000);
        send_body(100, 0, 0);
        send_body(100, 0, 1048575);
        send_body(1, 0, 1048575);
        send_body(0, 0, 0);
        send_body(32767, 0, 1048575);
        send_body(-32768, 32767, 200000);
        send_body(0, 32767, 1048575);
        send_body(0, -32768, 50000);
        send_body(200, 5000, 1048575);
        send_body(200, -5000, 1048575);
        send_body(-1, -1, 1048575);
        send_body(32767, 32767, 1048575);
        send_body(-32768, -32768, 1048575);
        send_body(32767, -32768, 3);
        send_body(-32768, 0, 999999);
        send_body(0, 0, 1048575);
        wait_drained();

        write_registers(1000, 2000000, 16000000, 100000);
        run_random(150);
        wait_drained();

        write_registers(0, 0, 0, 0);
        run_random(30);
        wait_drained();

        // upper data bits beyond the register width are dropped
        write_registers(int'(($urandom_range(1, 16383) << HT_W) | $urandom_range(0, 1000)),
                        $urandom_range(0, 2000000), $urandom_range(0, 16000000),
                        $urandom_range(0, 100000));
        run_random(150);
        wait_drained();

        write_registers(40, 5000, 200000, 300);
        run_random(150);
        wait_drained();

        idle_on = 1'b0;
        write_registers(40, 100000, 1500000, 1000);
        run_random(120);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ddwcs_pkg.sv
rtl/ddwcs_in_if.sv
rtl/ddwcs_out_if.sv
rtl/ddwcs_mul.sv
rtl/ddwcs_div.sv
rtl/diff_drive_wheel_command_slew.sv
dv/wheel_command_checker.sv
dv/tb_top.sv
